### rtl/box_blur_3x3_stream_unit_assert.svh
// Assertion macros for the 3x3 box blur stream unit.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef BOX_BLUR_3X3_STREAM_UNIT_ASSERT_SVH
`define BOX_BLUR_3X3_STREAM_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define BBS_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
`define BBS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define BBS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define BBS_ASSERT_ALWAYS(label, clk, rst_n, expr)
`define BBS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define BBS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### rtl/bbs_pkg.sv
// Shared constants and types for the 3x3 box blur stream unit.
// Depends on nothing.
package bbs_pkg;

    localparam int MAX_WIDTH    = 2048;
    localparam int MAX_HEIGHT   = 4096;
    localparam int RESET_WIDTH  = 640;
    localparam int RESET_HEIGHT = 480;

    localparam int PIX_W      = 8;
    localparam int CFG_W_BITS = 12;
    localparam int CFG_H_BITS = 13;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 1;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int WID_W  = $clog2(MAX_WIDTH + 1);
    localparam int H_W    = $clog2(MAX_HEIGHT + 2);
    localparam int ROW_W  = H_W;
    localparam int OROW_W = $clog2(MAX_HEIGHT);

    localparam int COLSUM_W = PIX_W + 2;
    localparam int SUM_W    = PIX_W + 4;

    // floor(s / 9) == (s * DIV9_MUL) >> DIV9_SHIFT for every s below 2^SUM_W
    localparam int DIV9_MUL   = 3641;
    localparam int DIV9_SHIFT = 15;
    localparam int PROD_W     = 2 * SUM_W;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

    typedef struct packed {
        logic interior;
        logic last;
    } t_item_flags;

endpackage

### rtl/box_blur_3x3_stream_unit.sv
// Top level of the 3x3 box blur stream unit: counters, line stores, window, divide.
// Depends on bbs_pkg, bbs_ram and box_blur_3x3_stream_unit_assert.svh.
//
// Takes one pixel or flush item per clock and gives at most one result per clock,
// sustained one item per cycle unless the output stalls; the limit is the single
// write port of each line store, written once per item. The item completing a 3x3
// neighbourhood passes stages A, B, C and the output register (input k+W+1 for
// output k). W+1 flush items after the frame drain the last row. Flush items that
// arrive while pixels are still expected are taken and dropped. The line stores
// need no clearing pass after reset: every stored value that can reach an output
// was written earlier in the same frame. A configuration write restarts the frame.
`include "box_blur_3x3_stream_unit_assert.svh"

module box_blur_3x3_stream_unit
    import bbs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [PIX_W-1:0]      i_pixel_in,
    input  logic                  i_flush,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [PIX_W-1:0]      o_pixel_out,
    output logic                  o_last_of_frame,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // frame geometry and stream position
    logic [WID_W-1:0]  r_w;
    logic [H_W-1:0]    r_h;
    logic [COL_W-1:0]  r_col, n_col;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [COL_W-1:0]  r_ocol, n_ocol;
    logic [OROW_W-1:0] r_orow, n_orow;

    logic [CFG_W_BITS-1:0] w_cfg_wraw;
    logic [CFG_H_BITS-1:0] w_cfg_hraw;
    logic [WID_W-1:0]      w_cfg_wsat;
    logic [H_W-1:0]        w_cfg_hsat;

    logic acc, keep, acc_drain, acc_instore, acc_emit;
    t_item_flags acc_flags;
    logic [PIX_W-1:0] acc_pix;

    // stage A: item with line store read data
    logic             r_a_valid;
    logic [COL_W-1:0] r_a_col;
    logic [PIX_W-1:0] r_a_pix;
    logic             r_a_instore;
    logic             r_a_emit;
    t_item_flags      r_a_flags;
    logic             r_byp_hit;
    logic [PIX_W-1:0] r_byp_up, r_byp_mid;
    logic [PIX_W-1:0] w_up_rd, w_mid_rd;
    logic [PIX_W-1:0] w_top_e, w_mid_e, w_top_v, w_mid_v;
    logic [COLSUM_W-1:0] w_colsum;
    logic ram_we;

    // window state: column sums and centre column
    logic [COLSUM_W-1:0] r_cs0, r_cs1, r_cs2;
    logic [PIX_W-1:0]    r_m4, r_m5;

    // stage B: window snapshot
    logic                r_b_valid;
    logic [COLSUM_W-1:0] r_b_cs0, r_b_cs1, r_b_cs2;
    logic [PIX_W-1:0]    r_b_ctr;
    t_item_flags         r_b_flags;

    // stage C: neighbourhood sum
    logic             r_c_valid;
    logic [SUM_W-1:0] r_c_sum;
    logic [PIX_W-1:0] r_c_ctr;
    t_item_flags      r_c_flags;
    logic [PROD_W-1:0] w_prod;
    logic [PIX_W-1:0]  w_quot;

    // output register
    logic             r_o_valid;
    logic [PIX_W-1:0] r_o_pix;
    logic             r_o_last;

    logic rdy_o, rdy_c, rdy_b, rdy_a, adv_a;

    assign rdy_o = !r_o_valid || i_out_ready;
    assign rdy_c = !r_c_valid || rdy_o;
    assign rdy_b = !r_b_valid || rdy_c;
    assign adv_a = r_a_valid && (!r_a_emit || rdy_b);
    assign rdy_a = !r_a_valid || adv_a;

    assign o_in_ready  = rdy_a;
    assign o_cfg_ready = 1'b1;

    // accept side
    assign acc         = i_in_valid && rdy_a;
    assign acc_drain   = r_row >= ROW_W'(r_h);
    assign keep        = acc && (acc_drain || !i_flush);
    assign acc_instore = r_row <= ROW_W'(r_h);
    assign acc_pix     = acc_drain ? '0 : i_pixel_in;
    assign acc_emit    = (r_row >= ROW_W'(2)) || ((r_row == ROW_W'(1)) && (r_col != '0));
    assign acc_flags.last     = r_row == (ROW_W'(r_h) + ROW_W'(1));
    assign acc_flags.interior = (r_orow != '0)
                              && ((H_W'(r_orow) + H_W'(2)) <= r_h)
                              && (r_ocol != '0)
                              && ((WID_W'(r_ocol) + WID_W'(2)) <= r_w);

    always_comb begin
        n_col  = r_col;
        n_row  = r_row;
        n_ocol = r_ocol;
        n_orow = r_orow;
        if (i_cfg_valid || (keep && acc_flags.last)) begin
            n_col  = '0;
            n_row  = '0;
            n_ocol = '0;
            n_orow = '0;
        end else if (keep) begin
            if ((WID_W'(r_col) + WID_W'(1)) >= r_w) begin
                n_col = '0;
                n_row = r_row + ROW_W'(1);
            end else begin
                n_col = r_col + COL_W'(1);
            end
            if (acc_emit) begin
                if ((WID_W'(r_ocol) + WID_W'(1)) >= r_w) begin
                    n_ocol = '0;
                    n_orow = r_orow + OROW_W'(1);
                end else begin
                    n_ocol = r_ocol + COL_W'(1);
                end
            end
        end
    end

    // configuration saturation
    assign w_cfg_wraw = i_cfg_data[CFG_W_BITS-1:0];
    assign w_cfg_hraw = i_cfg_data[CFG_H_BITS-1:0];

    always_comb begin
        if (w_cfg_wraw == '0) begin
            w_cfg_wsat = WID_W'(1);
        end else if (32'(w_cfg_wraw) > MAX_WIDTH) begin
            w_cfg_wsat = WID_W'(MAX_WIDTH);
        end else begin
            w_cfg_wsat = WID_W'(w_cfg_wraw);
        end
        if (w_cfg_hraw == '0) begin
            w_cfg_hsat = H_W'(1);
        end else if (32'(w_cfg_hraw) > MAX_HEIGHT) begin
            w_cfg_hsat = H_W'(MAX_HEIGHT);
        end else begin
            w_cfg_hsat = H_W'(w_cfg_hraw);
        end
    end

    // line stores
    assign w_top_e  = r_byp_hit ? r_byp_up  : w_up_rd;
    assign w_mid_e  = r_byp_hit ? r_byp_mid : w_mid_rd;
    assign w_top_v  = r_a_instore ? w_top_e : '0;
    assign w_mid_v  = r_a_instore ? w_mid_e : '0;
    assign w_colsum = COLSUM_W'(w_top_v) + COLSUM_W'(w_mid_v)
                    + COLSUM_W'(r_a_instore ? r_a_pix : '0);
    assign ram_we   = adv_a && r_a_instore;

    bbs_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_a_col),
        .i_wdata (w_mid_e),
        .i_re    (keep),
        .i_raddr (r_col),
        .o_rdata (w_up_rd)
    );

    bbs_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_middle_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_a_col),
        .i_wdata (r_a_pix),
        .i_re    (keep),
        .i_raddr (r_col),
        .o_rdata (w_mid_rd)
    );

    // divide by nine
    assign w_prod = PROD_W'(r_c_sum) * PROD_W'(DIV9_MUL);
    assign w_quot = w_prod[DIV9_SHIFT +: PIX_W];

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w       <= WID_W'(RESET_WIDTH);
            r_h       <= H_W'(RESET_HEIGHT);
            r_col     <= '0;
            r_row     <= '0;
            r_ocol    <= '0;
            r_orow    <= '0;
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_o_valid <= 1'b0;
            r_byp_hit <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_IMAGE_WIDTH:  r_w <= w_cfg_wsat;
                    CFG_IMAGE_HEIGHT: r_h <= w_cfg_hsat;
                    default:          r_w <= r_w;
                endcase
            end
            r_col     <= n_col;
            r_row     <= n_row;
            r_ocol    <= n_ocol;
            r_orow    <= n_orow;
            r_a_valid <= keep || (r_a_valid && !adv_a);
            r_b_valid <= (adv_a && r_a_emit) || (r_b_valid && !rdy_c);
            r_c_valid <= (r_b_valid && rdy_c) || (r_c_valid && !rdy_o);
            r_o_valid <= (r_c_valid && rdy_o) || (r_o_valid && !i_out_ready);
            if (keep) begin
                r_byp_hit <= ram_we && (r_a_col == r_col);
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (keep) begin
            r_a_col     <= r_col;
            r_a_pix     <= acc_pix;
            r_a_instore <= acc_instore;
            r_a_emit    <= acc_emit;
            r_a_flags   <= acc_flags;
            r_byp_up    <= w_mid_e;
            r_byp_mid   <= r_a_pix;
        end
        if (adv_a) begin
            r_cs0 <= r_cs1;
            r_cs1 <= r_cs2;
            r_cs2 <= w_colsum;
            r_m4  <= r_m5;
            r_m5  <= w_mid_v;
        end
        if (adv_a && r_a_emit) begin
            r_b_cs0   <= r_cs1;
            r_b_cs1   <= r_cs2;
            r_b_cs2   <= w_colsum;
            r_b_ctr   <= r_m5;
            r_b_flags <= r_a_flags;
        end
        if (r_b_valid && rdy_c) begin
            r_c_sum   <= SUM_W'(r_b_cs0) + SUM_W'(r_b_cs1) + SUM_W'(r_b_cs2);
            r_c_ctr   <= r_b_ctr;
            r_c_flags <= r_b_flags;
        end
        if (r_c_valid && rdy_o) begin
            r_o_pix  <= r_c_flags.interior ? w_quot : r_c_ctr;
            r_o_last <= r_c_flags.last;
        end
    end

    assign o_out_valid     = r_o_valid;
    assign o_pixel_out     = r_o_pix;
    assign o_last_of_frame = r_o_last;

    `BBS_ASSERT_NEXT(a_frame_restart, i_clk, i_rst_n, keep && acc_flags.last, (r_row == '0) && (r_col == '0) && (r_ocol == '0))
    `BBS_ASSERT_IMPLIES(a_bypass_width, i_clk, i_rst_n, r_a_valid && r_byp_hit, r_w == WID_W'(1))
    `BBS_ASSERT_ALWAYS(a_pos_in_row, i_clk, i_rst_n, (WID_W'(r_col) < r_w) && (WID_W'(r_ocol) < r_w))

endmodule

### rtl/bbs_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module bbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
